@@ hw/rtl/woffa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package woffa_pkg;

    localparam int WORDS    = 64;
    localparam int PID_BITS = 8;
    localparam int IDX_W    = $clog2(WORDS);
    localparam int CW       = (IDX_W + 1 > 7) ? IDX_W + 1 : 7;

    localparam int SIZE_W  = 7;
    localparam int WORD_W  = 6;
    localparam int PIDIN_W = 8;
    localparam int OWN_W   = 8;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        MODE_FIND  = 2'd0,
        MODE_CLAIM = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                used;
        logic [PID_BITS-1:0] owner;
    } t_cell;

    typedef struct packed {
        t_mode              mode;
        logic [SIZE_W-1:0]  block_size;
        logic [WORD_W-1:0]  first_word;
        logic [WORD_W-1:0]  last_word;
        logic [PIDIN_W-1:0] process_id;
        logic [WORD_W-1:0]  word_index;
    } t_item;

    typedef struct packed {
        logic             clear;
        logic             step;
        logic [IDX_W-1:0] idx;
    } t_head_ctl;

    typedef struct packed {
        t_status           status;
        logic [WORD_W-1:0] found_start;
        logic [OWN_W-1:0]  owner_id;
        logic              owner_valid;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/word_owner_first_fit_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | fields, lowest bit first
// s_axis   | in  | tuser: mode[1:0]; tdata: block_size[6:0] first_word[12:7]
//          |     |   last_word[18:13] process_id[26:19] word_index[32:27]
// m_axis   | out | tuser: status[1:0]; tdata: found_start[5:0] owner_id[13:6]
//          |     |   owner_valid[14]
//
// every command rotates the 64-cell map once through the head unit, then posts the
// result once the output register is free and returns to idle for the next transfer
// the head unit sees the words in ascending order, one per cycle
// synchronous active-low reset marks every word free; owner ids are not cleared
// a command is taken while an earlier result waits in the output register;
// the result is posted once that register is free

module word_owner_first_fit_allocator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    input  wire logic [woffa_pkg::S_TDATA_W-1:0] s_axis_tdata,  // block_size first_word last_word process_id word_index
    input  wire logic [woffa_pkg::S_TUSER_W-1:0] s_axis_tuser,  // mode
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output      logic [woffa_pkg::M_TDATA_W-1:0] m_axis_tdata,  // found_start owner_id owner_valid
    output      logic [woffa_pkg::M_TUSER_W-1:0] m_axis_tuser   // status
);
    import woffa_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_cnt;
    t_item            r_item;
    logic             r_m_valid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [M_TUSER_W-1:0] r_m_tuser;

    logic      accept;
    logic      last_word;
    logic      load_out;
    logic      shift;
    t_head_ctl head_ctl;
    t_result   result;
    t_cell     cells [WORDS];
    t_cell     tail_in;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign last_word = (r_cnt == IDX_W'(WORDS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_RUN;
            S_RUN:  if (last_word) n_state = S_DONE;
            S_DONE: if (!r_m_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        shift         = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_RUN:  shift = 1'b1;
            S_DONE: load_out = !r_m_valid || m_axis_tready;
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= '0;
            end else if (shift) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.mode       <= t_mode'(s_axis_tuser);
            r_item.block_size <= s_axis_tdata[6:0];
            r_item.first_word <= s_axis_tdata[12:7];
            r_item.last_word  <= s_axis_tdata[18:13];
            r_item.process_id <= s_axis_tdata[26:19];
            r_item.word_index <= s_axis_tdata[32:27];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_tdata <= {1'b0, result.owner_valid, result.owner_id, result.found_start};
            r_m_tuser <= result.status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    assign head_ctl.clear = accept;
    assign head_ctl.step  = shift;
    assign head_ctl.idx   = r_cnt;

    woffa_head u_head (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (r_item),
        .i_ctl    (head_ctl),
        .i_cell   (cells[0]),
        .o_cell   (tail_in),
        .o_result (result)
    );

    for (genvar g = 0; g < WORDS; g++) begin : g_cell
        if (g == WORDS - 1) begin : g_tail
            woffa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_cell  (tail_in),
                .o_cell  (cells[g])
            );
        end else begin : g_body
            woffa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_cell  (cells[g+1]),
                .o_cell  (cells[g])
            );
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/woffa_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module woffa_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_shift,
    input  wire woffa_pkg::t_cell  i_cell,
    output woffa_pkg::t_cell       o_cell
);
    import woffa_pkg::*;

    logic                r_used;
    logic [PID_BITS-1:0] r_owner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_shift) begin
            r_used <= i_cell.used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_owner <= i_cell.owner;
        end
    end

    assign o_cell.used  = r_used;
    assign o_cell.owner = r_owner;

endmodule

`default_nettype wire

@@ hw/rtl/woffa_head.sv @@
`timescale 1ns / 1ps
`default_nettype none

module woffa_head (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire woffa_pkg::t_item      i_item,
    input  wire woffa_pkg::t_head_ctl  i_ctl,
    input  wire woffa_pkg::t_cell      i_cell,
    output woffa_pkg::t_cell           o_cell,
    output woffa_pkg::t_result         o_result
);
    import woffa_pkg::*;

    logic [CW-1:0]       r_run;
    logic                r_found;
    logic [WORD_W-1:0]   r_start;
    logic                r_own_valid;
    logic [PID_BITS-1:0] r_owner;

    logic [CW-1:0] c_ext;
    logic [CW-1:0] first_ext;
    logic [CW-1:0] last_ext;
    logic [CW-1:0] size_ext;
    logic [CW-1:0] widx_ext;
    logic [CW-1:0] n_run;
    logic [CW-1:0] start_full;
    logic          in_range;
    logic          hit;

    assign c_ext      = CW'(i_ctl.idx);
    assign first_ext  = CW'(i_item.first_word);
    assign last_ext   = CW'(i_item.last_word);
    assign size_ext   = CW'(i_item.block_size);
    assign widx_ext   = CW'(i_item.word_index);
    assign in_range   = (c_ext >= first_ext) && (c_ext <= last_ext);
    assign n_run      = i_cell.used ? '0 : r_run + CW'(1);
    assign start_full = c_ext + CW'(1) - size_ext;
    assign hit        = (i_item.mode == MODE_FIND) && !r_found
                        && (i_item.block_size != '0) && (n_run == size_ext);

    // write-back of the word leaving the head towards the tail
    always_comb begin
        o_cell = i_cell;
        unique case (i_item.mode)
            MODE_CLAIM: begin
                if (in_range) begin
                    o_cell.used  = 1'b1;
                    o_cell.owner = PID_BITS'(i_item.process_id);
                end
            end
            MODE_FREE: begin
                if (in_range) begin
                    o_cell.used = 1'b0;
                end
            end
            default: begin
                o_cell = i_cell;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_found     <= 1'b0;
            r_own_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_run       <= '0;
            r_found     <= 1'b0;
            r_own_valid <= 1'b0;
        end else if (i_ctl.step) begin
            r_run <= n_run;
            if (hit) begin
                r_found <= 1'b1;
            end
            if ((i_item.mode == MODE_QUERY) && (c_ext == widx_ext) && i_cell.used) begin
                r_own_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            if (hit) begin
                r_start <= WORD_W'(start_full);
            end
            if (c_ext == widx_ext) begin
                r_owner <= i_cell.owner;
            end
        end
    end

    always_comb begin
        o_result.found_start = r_found ? r_start : '0;
        o_result.owner_valid = r_own_valid;
        o_result.owner_id    = r_own_valid ? OWN_W'(r_owner) : '0;
        unique case (i_item.mode) inside
            MODE_FIND:  o_result.status = r_found ? ST_DONE : ST_NOT_FOUND;
            MODE_CLAIM,
            MODE_FREE:  o_result.status = (i_item.last_word < i_item.first_word)
                                          ? ST_BAD_RANGE : ST_DONE;
            default:    o_result.status = ST_DONE;
        endcase
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import woffa_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 650;
    localparam int DRAIN_EVERY = 325;
    localparam int TAIL_CYCLES = 80;

    typedef struct {
        t_item   cmd;
        bit      typed;
        t_result want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // block_size first_word last_word process_id word_index
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;  // mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;       // found_start owner_id owner_valid
    logic [M_TUSER_W-1:0] m_axis_tuser;       // status

    word_owner_first_fit_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // shadow of the ownership map
    bit [WORDS-1:0]      word_used = '0;
    logic [PID_BITS-1:0] word_owner [WORDS];

    t_result     pending_results [$];
    t_row        directed [$];
    int unsigned src_gap_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned issued = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    function automatic bit first_fit(input int unsigned want, output int unsigned start);
        int unsigned run;
        run = 0;
        start = 0;
        if (want == 0 || want > WORDS) return 1'b0;
        for (int i = 0; i < WORDS; i++) begin
            run = word_used[i] ? 0 : run + 1;
            if (run == want) begin
                start = i + 1 - want;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_result map_apply(input t_item it);
        t_result     r;
        int unsigned at;
        r = '0;
        case (it.mode) inside
            MODE_FIND: begin
                if (first_fit(32'(it.block_size), at)) r.found_start = at[WORD_W-1:0];
                else r.status = ST_NOT_FOUND;
            end
            MODE_CLAIM, MODE_FREE: begin
                if (it.last_word < it.first_word) begin
                    r.status = ST_BAD_RANGE;
                end else begin
                    for (int w = 32'(it.first_word); w <= 32'(it.last_word); w++) begin
                        if (w < WORDS) begin
                            word_used[w]  = (it.mode == MODE_CLAIM);
                            word_owner[w] = (it.mode == MODE_CLAIM) ?
                                            it.process_id[PID_BITS-1:0] : '0;
                        end
                    end
                end
            end
            default: begin
                if (it.word_index < WORDS && word_used[it.word_index]) begin
                    r.owner_valid = 1'b1;
                    r.owner_id    = OWN_W'(word_owner[it.word_index]);
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.mode       = t_mode'($urandom_range(0, 3));
        it.block_size = SIZE_W'($urandom_range(0, 127));
        it.first_word = WORD_W'($urandom_range(0, 63));
        it.last_word  = WORD_W'($urandom_range(0, 63));
        it.process_id = PIDIN_W'($urandom_range(0, 255));
        it.word_index = WORD_W'($urandom_range(0, 63));
        return it;
    endfunction

    task automatic add_row(input t_mode m, input int sz, input int fw, input int lw,
                           input int pid, input int wi, input bit typed,
                           input t_status st, input int fs, input int own, input bit ov);
        t_row row;
        row.cmd.mode         = m;
        row.cmd.block_size   = SIZE_W'(sz);
        row.cmd.first_word   = WORD_W'(fw);
        row.cmd.last_word    = WORD_W'(lw);
        row.cmd.process_id   = PIDIN_W'(pid);
        row.cmd.word_index   = WORD_W'(wi);
        row.typed            = typed;
        row.want.status      = st;
        row.want.found_start = WORD_W'(fs);
        row.want.owner_id    = OWN_W'(own);
        row.want.owner_valid = ov;
        directed.push_back(row);
    endtask

    // leaves tvalid high after the transfer so the next command can follow back to back
    task automatic send_item(input t_item it, input bit typed, input t_result want);
        t_result predicted;
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, it.word_index, it.process_id, it.last_word,
                          it.first_word, it.block_size};
        s_axis_tuser  <= it.mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = map_apply(it);
        pending_results.push_back(typed ? want : predicted);
        issued++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // find a run; if one fits, claim it for a random owner and look at one of its words, else free a range
    task automatic alloc_sequence();
        t_item       it;
        int unsigned sz, at;
        sz = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        it = random_item();
        it.mode = MODE_FIND;
        it.block_size = SIZE_W'(sz);
        send_item(it, 1'b0, '0);
        it = random_item();
        if (first_fit(sz, at)) begin
            it.mode       = MODE_CLAIM;
            it.first_word = WORD_W'(at);
            it.last_word  = WORD_W'(at + sz - 1);
            send_item(it, 1'b0, '0);
            it = random_item();
            it.mode       = MODE_QUERY;
            it.word_index = WORD_W'(at + $urandom_range(0, sz - 1));
        end else begin
            it.mode       = MODE_FREE;
            it.first_word = WORD_W'($urandom_range(0, 63));
            it.last_word  = WORD_W'((32'(it.first_word) + sz > 63) ?
                                    63 : 32'(it.first_word) + sz);
        end
        send_item(it, 1'b0, '0);
    endtask

    // query a word and release the area around it when it is owned
    task automatic release_sequence();
        t_item it;
        int    lo, hi;
        it = random_item();
        it.mode = MODE_QUERY;
        send_item(it, 1'b0, '0);
        if (word_used[it.word_index]) begin
            lo = int'(it.word_index) - int'($urandom_range(0, 4));
            hi = int'(it.word_index) + int'($urandom_range(0, 8));
            it = random_item();
            it.mode       = MODE_FREE;
            it.first_word = WORD_W'((lo < 0) ? 0 : lo);
            it.last_word  = WORD_W'((hi > 63) ? 63 : hi);
            send_item(it, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin : sink
        t_result got, want;
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status      = t_status'(m_axis_tuser);
            got.found_start = m_axis_tdata[5:0];
            got.owner_id    = m_axis_tdata[13:6];
            got.owner_valid = m_axis_tdata[14];
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: status %0d", got.status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.found_start !== want.found_start) begin
                    $error("found_start: expected %0d, got %0d",
                           want.found_start, got.found_start);
                    mismatches++;
                end
                if (got.owner_id !== want.owner_id) begin
                    $error("owner_id: expected %0d, got %0d", want.owner_id, got.owner_id);
                    mismatches++;
                end
                if (got.owner_valid !== want.owner_valid) begin
                    $error("owner_valid: expected %0d, got %0d",
                           want.owner_valid, got.owner_valid);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int unsigned pick, phase_end;
        t_item       it;

        add_row(MODE_QUERY, 0, 0, 0, 0, 0, 1, ST_DONE, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 0, 0, 63, 1, ST_DONE, 0, 0, 0);
        add_row(MODE_FIND, 0, 0, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0);
        add_row(MODE_FIND, 65, 0, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0);
        add_row(MODE_FIND, 127, 0, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0);
        add_row(MODE_FIND, 64, 0, 0, 0, 0, 1, ST_DONE, 0, 0, 0);
        add_row(MODE_FIND, 1, 0, 0, 0, 0, 1, ST_DONE, 0, 0, 0);
        add_row(MODE_CLAIM, 0, 63, 0, 1, 0, 1, ST_BAD_RANGE, 0, 0, 0);
        add_row(MODE_FREE, 0, 10, 5, 0, 0, 1, ST_BAD_RANGE, 0, 0, 0);
        add_row(MODE_CLAIM, 0, 0, 63, 255, 0, 1, ST_DONE, 0, 0, 0);
        add_row(MODE_FIND, 1, 0, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 0, 0, 63, 1, ST_DONE, 0, 255, 1);
        add_row(MODE_QUERY, 0, 0, 0, 0, 0, 1, ST_DONE, 0, 255, 1);
        add_row(MODE_FREE, 0, 0, 0, 0, 0, 1, ST_DONE, 0, 0, 0);
        add_row(MODE_FIND, 1, 0, 0, 0, 0, 0, ST_DONE, 0, 0, 0);
        add_row(MODE_FIND, 2, 0, 0, 0, 0, 0, ST_DONE, 0, 0, 0);
        add_row(MODE_CLAIM, 0, 5, 5, 0, 0, 0, ST_DONE, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 0, 0, 5, 0, ST_DONE, 0, 0, 0);
        add_row(MODE_FREE, 0, 32, 63, 0, 0, 0, ST_DONE, 0, 0, 0);
        add_row(MODE_FIND, 32, 0, 0, 0, 0, 0, ST_DONE, 0, 0, 0);
        add_row(MODE_FIND, 33, 0, 0, 0, 0, 0, ST_DONE, 0, 0, 0);
        add_row(MODE_CLAIM, 0, 63, 63, 90, 0, 0, ST_DONE, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 0, 0, 62, 0, ST_DONE, 0, 0, 0);
        add_row(MODE_FREE, 0, 0, 63, 0, 0, 1, ST_DONE, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 0, 0, 63, 1, ST_DONE, 0, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_gap_pct    = 31;
        sink_stall_pct = 64;
        foreach (directed[k]) send_item(directed[k].cmd, directed[k].typed, directed[k].want);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            src_gap_pct    = (phase == 0) ? 31 : (phase == 1) ? 64 : 0;
            sink_stall_pct = (phase == 0) ? 64 : (phase == 1) ? 31 : 0;
            phase_end = issued + PHASE_ITEMS;
            while (issued < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    alloc_sequence();
                end else if (pick < 68) begin
                    release_sequence();
                end else if (pick < 71) begin
                    it = random_item();
                    it.mode       = MODE_FREE;
                    it.first_word = '0;
                    it.last_word  = WORD_W'(63);
                    send_item(it, 1'b0, '0);
                end else begin
                    send_item(random_item(), 1'b0, '0);
                end
                if (issued % DRAIN_EVERY < 3 && issued >= DRAIN_EVERY) drain_results();
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
